[hw/rtl/dns_name_to_dotted_text_macros.svh]
// assertion macros for the dns name to dotted text block
// expects clk_i and rst_ni in the scope of the including module
`ifndef DNS_NAME_TO_DOTTED_TEXT_MACROS_SVH
`define DNS_NAME_TO_DOTTED_TEXT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DNT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// implication checked in the same cycle
`define DNT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dnt_pkg.sv]
// shared types and constants of the dns name to dotted text block
// no dependencies
`default_nettype none

package dnt_pkg;

  // wire format limits
  localparam logic [7:0] MAX_LABEL = 8'd63;
  localparam logic [8:0] MAX_NAME  = 9'd255;

  // text characters
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // error codes of a result
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_NAME_LONG  = 2'd1;
  localparam logic [1:0] ERR_LABEL_LONG = 2'd2;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_END,
    CMD_ERR
  } cmd_kind_e;

  // one classified byte
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] value;  // data byte
    logic       flag;   // data: dot follows, end: root name
    logic [1:0] err;    // error code for CMD_ERR
  } cmd_t;

  // queue status seen by the back end
  typedef struct packed {
    logic head_valid;
    cmd_t head;
  } q_head_t;

endpackage

`default_nettype wire

[hw/rtl/dns_name_to_dotted_text.sv]
// top level of the dns wire-format name to dotted text converter
// depends on dnt_pkg, dnt_front, dnt_queue, dnt_back and the macros header
`default_nettype none
`include "dns_name_to_dotted_text_macros.svh"

// Takes a wire-format DNS name one byte per push and gives its dotted text
// form one character per pop, closing each name with a NUL flagged is_last
// (or an error result with out_char 0). The front end takes one byte every
// cycle while the command queue (QUEUE_DEPTH entries) has room; the back
// end emits one character per cycle into its output register while it is
// empty or popped. A label's length byte yields none, a plain data byte
// one, the last byte of a label one more for the dot, an escaped control
// byte up to five, so a byte yields 0 to 5 characters and the sustained
// rate is bounded by that one character per cycle. cfg writes the escape
// character and is always ready; write it only while no name is in flight.
module dns_name_to_dotted_text import dnt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] name_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char_o,
  output logic            is_last_o,
  output logic [1:0]      error_code_o
);

  logic [7:0] esc_q;
  logic       accept, enq, deq;
  cmd_t       cmd;
  q_head_t    head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // escape character register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      esc_q <= cfg_data_i;
    end
  end

  // byte parser
  dnt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .name_byte_i (name_byte_i),
    .enq_o       (enq),
    .cmd_o       (cmd)
  );

  // command queue
  dnt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .cmd_i  (cmd),
    .deq_i  (deq),
    .full_o (full),
    .head_o (head)
  );

  // character generator
  dnt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .escape_char_i (esc_q),
    .head_i        (head),
    .deq_o         (deq),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_char_o    (out_char_o),
    .is_last_o     (is_last_o),
    .error_code_o  (error_code_o)
  );

  // checks
  `DNT_ASSERT_ALWAYS(a_no_enq_when_full, !(enq && full), "command lost at full queue")
  `DNT_ASSERT_IMPL(a_err_is_last, !empty && error_code_o != ERR_OK, is_last_o, "error result not last")
  `DNT_ASSERT_IMPL(a_last_is_nul, !empty && is_last_o, out_char_o == CHAR_NUL, "last result not NUL")
  `DNT_ASSERT_IMPL(a_deq_has_head, deq, head.head_valid, "dequeue from empty queue")

endmodule

`default_nettype wire

[hw/rtl/dnt_front.sv]
// front end: parses wire-format bytes and classifies them into commands
// depends on dnt_pkg
`default_nettype none

module dnt_front import dnt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] name_byte_i,
  output logic            enq_o,
  output cmd_t            cmd_o
);

  logic [7:0] pos_q, pos_d;
  logic [5:0] rem_q, rem_d;
  logic       expect_q, expect_d;
  logic [8:0] span;

  assign span = {1'b0, pos_q} + 9'd1 + {1'b0, name_byte_i};

  // classify the byte and advance the parse state
  always_comb begin
    pos_d       = pos_q;
    rem_d       = rem_q;
    expect_d    = expect_q;
    enq_o       = 1'b0;
    cmd_o.kind  = CMD_DATA;
    cmd_o.value = name_byte_i;
    cmd_o.flag  = 1'b0;
    cmd_o.err   = ERR_OK;
    if (accept_i) begin
      if (expect_q) begin
        if (name_byte_i == CHAR_NUL) begin
          enq_o      = 1'b1;
          cmd_o.kind = CMD_END;
          cmd_o.flag = (pos_q == 8'd0);
          pos_d      = 8'd0;
          rem_d      = 6'd0;
          expect_d   = 1'b1;
        end else if (span >= MAX_NAME) begin
          enq_o      = 1'b1;
          cmd_o.kind = CMD_ERR;
          cmd_o.err  = ERR_NAME_LONG;
          pos_d      = 8'd0;
          rem_d      = 6'd0;
          expect_d   = 1'b1;
        end else if (name_byte_i > MAX_LABEL) begin
          enq_o      = 1'b1;
          cmd_o.kind = CMD_ERR;
          cmd_o.err  = ERR_LABEL_LONG;
          pos_d      = 8'd0;
          rem_d      = 6'd0;
          expect_d   = 1'b1;
        end else begin
          // label start, nothing to emit
          rem_d    = name_byte_i[5:0];
          expect_d = 1'b0;
          pos_d    = pos_q + 8'd1;
        end
      end else begin
        enq_o      = 1'b1;
        cmd_o.kind = CMD_DATA;
        cmd_o.flag = (rem_q <= 6'd1);
        pos_d      = pos_q + 8'd1;
        rem_d      = (rem_q != 6'd0) ? rem_q - 6'd1 : 6'd0;
        if (rem_q <= 6'd1) begin
          expect_d = 1'b1;
        end
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 8'd0;
      rem_q    <= 6'd0;
      expect_q <= 1'b1;
    end else begin
      pos_q    <= pos_d;
      rem_q    <= rem_d;
      expect_q <= expect_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dnt_queue.sv]
// command queue between front and back end
// depends on dnt_pkg
`default_nettype none

module dnt_queue import dnt_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic enq_i,
  input  wire cmd_t cmd_i,
  input  wire logic deq_i,
  output logic      full_o,
  output q_head_t   head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o            = (cnt_q == FULL_CNT);
  assign head_o.head_valid = (cnt_q != '0);
  assign head_o.head       = mem_q[rd_q];
  assign do_wr             = enq_i && !full_o;
  assign do_rd             = deq_i && head_o.head_valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
      end
      if (do_rd) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dnt_back.sv]
// back end: expands commands into text characters, one per cycle while the output is empty or popped
// depends on dnt_pkg
`default_nettype none

module dnt_back import dnt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] escape_char_i,
  input  wire q_head_t    head_i,
  output logic            deq_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      out_char_o,
  output logic            is_last_o,
  output logic [1:0]      error_code_o
);

  logic [2:0] step_q, step_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] ochar_q;
  logic       olast_q;
  logic [1:0] oerr_q;

  cmd_t       cmd;
  logic       esc_on, is_ctl, is_dotesc, load, pop_ok;
  logic [2:0] body_len, total;
  logic [7:0] ch;
  logic       last;
  logic [1:0] tens;
  logic [5:0] ones;

  assign cmd       = head_i.head;
  assign esc_on    = (escape_char_i != CHAR_NUL);
  assign is_ctl    = esc_on && (cmd.value <= CHAR_SPACE);
  assign is_dotesc = esc_on && (cmd.value == CHAR_DOT);
  assign pop_ok    = pop_i && ovalid_q;
  assign load      = head_i.head_valid && (!ovalid_q || pop_ok);

  // decimal digits of a control byte, at most 32
  always_comb begin
    if (cmd.value[5:0] >= 6'd30) begin
      tens = 2'd3;
      ones = cmd.value[5:0] - 6'd30;
    end else if (cmd.value[5:0] >= 6'd20) begin
      tens = 2'd2;
      ones = cmd.value[5:0] - 6'd20;
    end else if (cmd.value[5:0] >= 6'd10) begin
      tens = 2'd1;
      ones = cmd.value[5:0] - 6'd10;
    end else begin
      tens = 2'd0;
      ones = cmd.value[5:0];
    end
  end

  // character for the current step of the command
  always_comb begin
    body_len = is_ctl ? 3'd4 : (is_dotesc ? 3'd2 : 3'd1);
    total    = 3'd1;
    ch       = CHAR_NUL;
    last     = 1'b0;
    case (cmd.kind)
      CMD_DATA: begin
        total = body_len + {2'b00, cmd.flag};
        if (step_q >= body_len) begin
          ch = CHAR_DOT;
        end else if (is_ctl) begin
          case (step_q)
            3'd0:    ch = escape_char_i;
            3'd1:    ch = CHAR_ZERO;
            3'd2:    ch = CHAR_ZERO + {6'd0, tens};
            default: ch = CHAR_ZERO + {2'b00, ones};
          endcase
        end else if (is_dotesc && step_q == 3'd0) begin
          ch = escape_char_i;
        end else begin
          ch = cmd.value;
        end
      end
      CMD_END: begin
        total = cmd.flag ? 3'd2 : 3'd1;
        if (cmd.flag && step_q == 3'd0) begin
          ch = CHAR_DOT;
        end else begin
          last = 1'b1;
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // step through the command and refill the output register
  always_comb begin
    step_d   = step_q;
    deq_o    = 1'b0;
    ovalid_d = ovalid_q;
    if (pop_ok) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d = 1'b1;
      if (step_q == total - 3'd1) begin
        step_d = 3'd0;
        deq_o  = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ochar_q <= ch;
      olast_q <= last;
      oerr_q  <= (cmd.kind == CMD_ERR) ? cmd.err : ERR_OK;
    end
  end

  assign empty_o      = !ovalid_q;
  assign out_char_o   = ochar_q;
  assign is_last_o    = olast_q;
  assign error_code_o = oerr_q;

endmodule

`default_nettype wire

[tb/tb_dns_name_to_dotted_text.sv]
// self-checking testbench for the dns wire-format name to dotted text converter
// depends on dnt_pkg and the dns_name_to_dotted_text top level
`timescale 1ns / 100ps

module tb_dns_name_to_dotted_text;
  import dnt_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int BUSY_PCT     = 38;
  localparam int PHASE_BYTES  = 60;

  // one text character as it leaves the block
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] err;
  } text_char_t;

  // directed stimulus table
  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;
    logic       typed;    // expected text written out below
    logic [1:0] n_typed;
    text_char_t r0;
    text_char_t r1;
  } stim_row_t;

  localparam text_char_t NO_CHAR  = '{CHAR_NUL, 1'b0, ERR_OK};
  localparam text_char_t DOT_CHAR = '{CHAR_DOT, 1'b0, ERR_OK};
  localparam text_char_t END_CHAR = '{CHAR_NUL, 1'b1, ERR_OK};
  localparam text_char_t NAME_ERR = '{CHAR_NUL, 1'b1, ERR_NAME_LONG};
  localparam text_char_t LBL_ERR  = '{CHAR_NUL, 1'b1, ERR_LABEL_LONG};

  localparam int N_ROWS = 23;
  localparam stim_row_t STIM_ROWS [N_ROWS] = '{
    // escaping off after reset
    '{ROW_BYTE, 8'h00, 1'b1, 2'd2, DOT_CHAR, END_CHAR},  // root name
    '{ROW_BYTE, 8'h40, 1'b1, 2'd1, LBL_ERR,  NO_CHAR},   // label of 64
    '{ROW_BYTE, 8'hff, 1'b1, 2'd1, NAME_ERR, NO_CHAR},   // name check wins over label
    '{ROW_BYTE, 8'hfe, 1'b1, 2'd1, NAME_ERR, NO_CHAR},   // reaches exactly 255
    '{ROW_BYTE, 8'h02, 1'b1, 2'd0, NO_CHAR,  NO_CHAR},   // label start, silent
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // raw zero data byte
    '{ROW_BYTE, 8'h2e, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // raw dot, label ends
    '{ROW_BYTE, 8'h00, 1'b1, 2'd1, END_CHAR, NO_CHAR},   // end of name
    // backslash escaping
    '{ROW_CFG,  8'h5c, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},
    '{ROW_BYTE, 8'h04, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},
    '{ROW_BYTE, 8'h2e, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // escaped dot
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // lowest control byte
    '{ROW_BYTE, 8'h20, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // space is escaped
    '{ROW_BYTE, 8'h21, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // first plain byte, label ends
    '{ROW_BYTE, 8'h01, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},
    '{ROW_BYTE, 8'hff, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // top data byte
    '{ROW_BYTE, 8'h00, 1'b1, 2'd1, END_CHAR, NO_CHAR},
    // highest escape character
    '{ROW_CFG,  8'hff, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},
    '{ROW_BYTE, 8'h01, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},
    '{ROW_BYTE, 8'h1f, 1'b0, 2'd0, NO_CHAR,  NO_CHAR},   // five characters from one byte
    '{ROW_BYTE, 8'h00, 1'b1, 2'd1, END_CHAR, NO_CHAR},
    '{ROW_BYTE, 8'h00, 1'b1, 2'd2, DOT_CHAR, END_CHAR},  // root name with escaping on
    '{ROW_BYTE, 8'h41, 1'b1, 2'd1, LBL_ERR,  NO_CHAR}
  };

  // block ports
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       push        = 1'b0;
  logic [7:0] name_byte_i = 8'h00;
  logic       pop         = 1'b0;
  logic       cfg_ready_o;
  logic       full;
  logic       empty;
  logic [7:0] out_char_o;
  logic       is_last_o;
  logic [1:0] error_code_o;

  // converter state mirrored by the predictor
  logic [7:0] escape_q    = 8'h00;
  logic [7:0] name_pos    = 8'h00;
  logic [5:0] label_left  = 6'd0;
  logic       want_length = 1'b1;

  text_char_t byte_text[$];
  text_char_t pending_text[$];

  int idle_pct      = BUSY_PCT;
  int fail_count    = 0;
  int bytes_sent    = 0;
  int chars_checked = 0;
  int names_closed  = 0;
  int errors_seen   = 0;

  dns_name_to_dotted_text dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .name_byte_i  (name_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .is_last_o    (is_last_o),
    .error_code_o (error_code_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("dns_name_to_dotted_text verification failed");
    $finish;
  end

  task automatic restart_name();
    name_pos    = 8'h00;
    label_left  = 6'd0;
    want_length = 1'b1;
  endtask

  // text produced by one wire byte, left in byte_text
  task automatic convert_byte(input logic [7:0] b);
    logic [7:0] d2, d1, d0;
    begin
      byte_text.delete();
      d2 = CHAR_ZERO + b / 8'd100;
      d1 = CHAR_ZERO + (b / 8'd10) % 8'd10;
      d0 = CHAR_ZERO + b % 8'd10;
      if (want_length) begin
        if (b == 8'h00) begin
          if (name_pos == 8'h00) byte_text.push_back(DOT_CHAR);
          byte_text.push_back(END_CHAR);
          restart_name();
        end else if (int'(name_pos) + 1 + int'(b) >= int'(MAX_NAME)) begin
          byte_text.push_back(NAME_ERR);
          restart_name();
        end else if (b > MAX_LABEL) begin
          byte_text.push_back(LBL_ERR);
          restart_name();
        end else begin
          label_left  = b[5:0];
          want_length = 1'b0;
          name_pos    = name_pos + 8'd1;
        end
      end else begin
        if (escape_q != 8'h00 && b == CHAR_DOT) begin
          byte_text.push_back('{escape_q, 1'b0, ERR_OK});
          byte_text.push_back('{b, 1'b0, ERR_OK});
        end else if (escape_q != 8'h00 && b <= CHAR_SPACE) begin
          byte_text.push_back('{escape_q, 1'b0, ERR_OK});
          byte_text.push_back('{d2, 1'b0, ERR_OK});
          byte_text.push_back('{d1, 1'b0, ERR_OK});
          byte_text.push_back('{d0, 1'b0, ERR_OK});
        end else begin
          byte_text.push_back('{b, 1'b0, ERR_OK});
        end
        name_pos = name_pos + 8'd1;
        if (label_left > 6'd0) label_left = label_left - 6'd1;
        if (label_left == 6'd0) begin
          byte_text.push_back(DOT_CHAR);
          want_length = 1'b1;
        end
      end
    end
  endtask

  // one byte request; push stays high so back-to-back requests need no gap
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    name_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    convert_byte(b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_byte(b);
    foreach (byte_text[k]) pending_text.push_back(byte_text[k]);
  endtask

  // sender holds off until all text is out, then writes the escape register
  task automatic write_escape(input logic [7:0] v);
    push <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    escape_q = v;
  endtask

  // data bytes biased toward dots and control bytes
  function automatic logic [7:0] label_char();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (r < 20) label_char = CHAR_DOT;
      else if (r < 45) label_char = 8'($urandom_range(0, 32));
      else label_char = 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic send_label(input int len);
    send_byte(8'(len));
    if (!want_length) repeat (len) send_byte(label_char());
  endtask

  // close whatever name is open so the block is at a name boundary
  task automatic finish_name();
    while (!want_length) send_byte(label_char());
    if (name_pos != 8'h00) send_byte(8'h00);
  endtask

  // mostly well-formed names, some broken ones and some raw noise
  task automatic random_phase(input int budget);
    int start, r, nlab, len;
    begin
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          nlab = $urandom_range(0, 4);
          repeat (nlab) begin
            len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 8);
            send_label(len);
          end
          send_byte(8'h00);
        end else if (r < 90) begin
          repeat ($urandom_range(0, 2)) send_label($urandom_range(1, 6));
          send_byte(8'($urandom_range(64, 255)));
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      finish_name();
    end
  endtask

  // result side: random pop, compare each accepted character
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_text.size() == 0) begin
        $error("unexpected text character %h last %b err %0d",
               out_char_o, is_last_o, error_code_o);
        fail_count++;
      end else begin
        want = pending_text.pop_front();
        chars_checked++;
        if (want.last) names_closed++;
        if (want.err != ERR_OK) errors_seen++;
        if (out_char_o !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, out_char_o);
          fail_count++;
        end
        if (is_last_o !== want.last) begin
          $error("is_last expected %b actual %b", want.last, is_last_o);
          fail_count++;
        end
        if (error_code_o !== want.err) begin
          $error("error_code expected %0d actual %0d", want.err, error_code_o);
          fail_count++;
        end
      end
    end
    if (rst_ni) pop <= ($urandom_range(0, 99) >= idle_pct);
  end

  // stimulus
  initial begin
    int i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < N_ROWS; i++) begin
      if (STIM_ROWS[i].kind == ROW_CFG) begin
        write_escape(STIM_ROWS[i].value);
      end else begin
        push_byte(STIM_ROWS[i].value);
        if (STIM_ROWS[i].typed) begin
          if (STIM_ROWS[i].n_typed > 2'd0) pending_text.push_back(STIM_ROWS[i].r0);
          if (STIM_ROWS[i].n_typed > 2'd1) pending_text.push_back(STIM_ROWS[i].r1);
        end else begin
          foreach (byte_text[k]) pending_text.push_back(byte_text[k]);
        end
      end
    end

    // random phases over several escape settings
    write_escape(8'h00);
    random_phase(PHASE_BYTES);

    write_escape(8'h5c);
    random_phase(PHASE_BYTES);

    // no idling on either side here
    write_escape(8'hff);
    idle_pct = 0;
    random_phase(PHASE_BYTES);
    idle_pct = BUSY_PCT;

    write_escape(8'($urandom_range(1, 255)));
    random_phase(PHASE_BYTES);

    // drain
    push <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d wire bytes, checked %0d characters", bytes_sent, chars_checked);
    $display("closed %0d names, %0d of them with an error", names_closed, errors_seen);
    if (fail_count == 0) begin
      $display("dns_name_to_dotted_text verification clean");
    end else begin
      $display("dns_name_to_dotted_text verification failed");
    end
    $finish;
  end

endmodule
